// ===== rtl/rsg_pkg.sv =====
`default_nettype none
package rsg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 14;
	localparam int KNEE_W     = 15;
	localparam int SEL_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// gained product: sample times zero-extended gain
	localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
	// gained value after the Q8 shift, plus one guard bit
	localparam int GAINED_W = PROD_W - 8 + 1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6 * 256);
	localparam logic [KNEE_W-1:0] KNEE_RESET = KNEE_W'(28000);
	localparam logic [SEL_W-1:0]  SEL_RESET  = SEL_W'(1);

	localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] SAT_LO = -16'sd32768;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEL  = 2'd2;

	// phase codes of the 3:2 frame sequence
	localparam logic [1:0] PH_PASS   = 2'd0;
	localparam logic [1:0] PH_HOLD   = 2'd1;
	localparam logic [1:0] PH_INTERP = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic load_hold;
		logic load_out;
		logic interp;
	} lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/rsg_lane.sv =====
`default_nettype none
module rsg_lane (
	input  wire                 clk,
	input  wire rsg_pkg::lane_ctl_t ctl,
	input  wire rsg_pkg::sample_t   sample,
	output rsg_pkg::sample_t    out_s1
);
	import rsg_pkg::*;

	sample_t                    held_q;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [SAMPLE_W:0]   half;
	logic signed [SAMPLE_W:0]   mid;
	sample_t                    lane_res;

	// a + floor((b - a) / 2); stays between a and b, so 16 bits suffice
	always_comb begin
		diff = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(held_q);
		half = diff >>> 1;
		mid  = (SAMPLE_W+1)'(held_q) + half;
		lane_res = ctl.interp ? mid[SAMPLE_W-1:0] : sample;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_hold) begin
			held_q <= sample;
		end
		if (ctl.load_out) begin
			out_s1 <= lane_res;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rsg_merge.sv =====
`default_nettype none
module rsg_merge #(
	parameter int LANES = 4
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  valid_s1,
	output logic                                 ready_s2,
	input  wire  [LANES*rsg_pkg::SAMPLE_W-1:0]   frame_s1,
	input  wire  [rsg_pkg::GAIN_W-1:0]           gain_q8,
	input  wire  [rsg_pkg::KNEE_W-1:0]           knee_level,
	input  wire  [rsg_pkg::SEL_W-1:0]            mic_lane_select,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [(LANES+1)*rsg_pkg::SAMPLE_W-1:0] m_tdata
);
	import rsg_pkg::*;

	localparam logic [3:0] LAST_LANE = 4'(LANES - 1);

	logic                          valid_s2;
	logic [LANES*SAMPLE_W-1:0]     frame_s2;
	logic signed [PROD_W-1:0]      prod_s2;
	logic                          ready_s3;
	logic [3:0]                    sel_eff;
	sample_t                       mic_x;
	logic signed [PROD_W-1:0]      prod;
	logic signed [GAINED_W-1:0]    g;
	logic signed [GAINED_W-1:0]    k;
	logic signed [GAINED_W-1:0]    t;
	sample_t                       mic_res;

	assign ready_s3 = !m_tvalid || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;

	// lane pick saturates at the top lane
	always_comb begin
		sel_eff = (4'(mic_lane_select) > LAST_LANE) ? LAST_LANE : 4'(mic_lane_select);
		mic_x = frame_s1[SAMPLE_W-1:0];
		for (int i = 0; i < LANES; i++) begin
			if (sel_eff == 4'(i)) begin
				mic_x = frame_s1[i*SAMPLE_W +: SAMPLE_W];
			end
		end
		prod = PROD_W'(mic_x) * $signed({1'b0, gain_q8});
	end

	// Q8 floor, soft knee, saturate
	always_comb begin
		g = GAINED_W'(prod_s2 >>> 8);
		k = $signed(GAINED_W'(knee_level));
		if (g > k) begin
			t = k + ((g - k) >>> 2);
		end else if (g < -k) begin
			t = -k + ((g + k) >>> 2);
		end else begin
			t = g;
		end
		if (t > GAINED_W'(SAT_HI)) begin
			mic_res = SAT_HI;
		end else if (t < GAINED_W'(SAT_LO)) begin
			mic_res = SAT_LO;
		end else begin
			mic_res = t[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				m_tvalid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			frame_s2 <= frame_s1;
			prod_s2  <= prod;
		end
		if (ready_s3 && valid_s2) begin
			m_tdata <= {mic_res, frame_s2};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/four_lane_3to2_resampler_soft_gain_top.sv =====
`default_nettype none
// 3:2 linear-interpolation resampler, LANES x 16-bit frames from 24 kHz to
// 16 kHz, with a soft-knee Q8 make-up gain on one selected mic lane. One frame
// is accepted every cycle unless the pipe stalls; of each three frames the
// first is passed through, the second is held and gives no result, the third
// emits the per-lane midpoint floor(a + (b - a) / 2) of held and current
// frames. Every result also carries mic_out. An emitted frame passes the lane
// register, the multiplier register and the output register before it shows
// on m_tvalid; each stage stalls while the one after it is full and cannot
// pass its result on, so a full pipe holds three results.
// The config channel is always ready; write registers only while the block
// is idle. No clearing pass after reset.
module four_lane_3to2_resampler_soft_gain_top #(
	parameter int LANES = 4
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	// lane0_sample .. lane(LANES-1)_sample, 16 bits each
	input  wire  [LANES*rsg_pkg::SAMPLE_W-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	// out_lane0 .. out_lane(LANES-1), then mic_out, 16 bits each
	output logic [(LANES+1)*rsg_pkg::SAMPLE_W-1:0] m_tdata,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [rsg_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [rsg_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import rsg_pkg::*;

	logic [GAIN_W-1:0]          gain_q;
	logic [KNEE_W-1:0]          knee_q;
	logic [SEL_W-1:0]           sel_q;
	logic [1:0]                 phase_q;
	logic                       valid_s1;
	logic                       ready_s1;
	logic                       ready_s2;
	logic                       accept;
	logic                       emit;
	lane_ctl_t                  ctl;
	logic [LANES*SAMPLE_W-1:0]  frame_s1;

	assign cfg_ready = 1'b1;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;
	assign accept    = s_tvalid && s_tready;
	assign emit      = (phase_q != PH_HOLD);

	always_comb begin
		ctl.load_hold = accept && (phase_q == PH_HOLD);
		ctl.load_out  = accept && emit;
		ctl.interp    = (phase_q == PH_INTERP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			knee_q <= KNEE_RESET;
			sel_q  <= SEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				REG_KNEE: knee_q <= cfg_data[KNEE_W-1:0];
				REG_SEL:  sel_q  <= cfg_data[SEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PASS;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				case (phase_q)
					PH_HOLD:   phase_q <= PH_INTERP;
					PH_INTERP: phase_q <= PH_PASS;
					default:   phase_q <= PH_HOLD;
				endcase
			end
			if (ready_s1) begin
				valid_s1 <= accept && emit;
			end
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		rsg_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.sample (s_tdata[i*SAMPLE_W +: SAMPLE_W]),
			.out_s1 (frame_s1[i*SAMPLE_W +: SAMPLE_W])
		);
	end

	rsg_merge #(
		.LANES (LANES)
	) u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.ready_s2        (ready_s2),
		.frame_s1        (frame_s1),
		.gain_q8         (gain_q),
		.knee_level      (knee_q),
		.mic_lane_select (sel_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

endmodule
`default_nettype wire

// ===== rtl/rsg_checker.sv =====
`default_nettype none
module rsg_checker #(
	parameter int LANES = 4
) (
	input wire                                    clk,
	input wire                                    arst_n,
	input wire                                    s_tvalid,
	input wire                                    s_tready,
	input wire                                    m_tvalid,
	input wire                                    m_tready,
	input wire [(LANES+1)*rsg_pkg::SAMPLE_W-1:0]  m_tdata
);
	import rsg_pkg::*;

	logic [1:0] ph_q;
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;
	logic       in_emit;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign in_emit = in_acc && (ph_q != PH_HOLD);

	// results owed: emitting requests taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_PASS;
			pend_q <= 3'd0;
		end else begin
			if (in_acc) begin
				case (ph_q)
					PH_HOLD:   ph_q <= PH_INTERP;
					PH_INTERP: ph_q <= PH_PASS;
					default:   ph_q <= PH_HOLD;
				endcase
			end
			pend_q <= pend_q + 3'(in_emit) - 3'(out_acc);
		end
	end

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 3'd0)
		else $error("result delivered with none owed");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more results owed than pipeline stages");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 3'd3 && !out_acc) |-> !s_tready)
		else $error("input taken while pipeline full");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

	// a held-phase request never raises a new result by itself
	a_hold_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ph_q == PH_HOLD && !out_acc) |=> pend_q == $past(pend_q))
		else $error("held frame produced a result");

endmodule

bind four_lane_3to2_resampler_soft_gain_top rsg_checker #(
	.LANES (LANES)
) u_rsg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== test/four_lane_3to2_resampler_soft_gain_top_tb.sv =====
`default_nettype none
module four_lane_3to2_resampler_soft_gain_top_tb;
	import rsg_pkg::*;

	localparam int LANES        = 4;
	localparam int IN_W         = LANES * SAMPLE_W;
	localparam int OUT_W        = (LANES + 1) * SAMPLE_W;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_ROUNDS  = 8;
	localparam int ROUND_ITEMS  = 165;

	// index past the end of the register map, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic [IN_W-1:0]       frame;
		bit                    typed;
		logic [OUT_W-1:0]      res;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// lane0 .. lane3 samples, 16 bits each
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// out_lane0 .. out_lane3, then mic_out
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state
	logic [1:0]            phase_q  = PH_PASS;
	sample_t               held_q [LANES];
	logic [GAIN_W-1:0]     gain_q   = GAIN_RESET;
	logic [KNEE_W-1:0]     knee_q   = KNEE_RESET;
	logic [SEL_W-1:0]      sel_q    = SEL_RESET;

	logic [OUT_W-1:0]      pending_frames [$];
	stim_row_t             directed_rows [$];
	logic [OUT_W-1:0]      want;
	int                    mismatches = 0;
	bit                    gaps_on    = 1'b1;

	four_lane_3to2_resampler_soft_gain_top #(.LANES(LANES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [IN_W-1:0] pack4(input int a, input int b, input int c,
			input int d);
		return {d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	function automatic logic [OUT_W-1:0] pack5(input int a, input int b, input int c,
			input int d, input int m);
		return {m[15:0], d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(0, 9))
			0: return 32767;
			1: return -32768;
			2: return 0;
			3: return -1;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// 3:2 resampler plus soft-knee gain on the selected lane
	task automatic resample_frame(input logic [IN_W-1:0] f, output bit emits,
			output logic [OUT_W-1:0] r);
		sample_t cur [LANES];
		int      d;
		int      si;
		longint  g;
		longint  k;
		for (int i = 0; i < LANES; i++)
			cur[i] = f[i*SAMPLE_W +: SAMPLE_W];
		emits = 1'b0;
		r = '0;
		if (phase_q == PH_HOLD) begin
			for (int i = 0; i < LANES; i++)
				held_q[i] = cur[i];
			phase_q = PH_INTERP;
		end else begin
			if (phase_q == PH_INTERP) begin
				// midpoint, rounded toward minus infinity
				for (int i = 0; i < LANES; i++) begin
					d = int'(cur[i]) - int'(held_q[i]);
					cur[i] = sample_t'(int'(held_q[i]) + (d >>> 1));
				end
				phase_q = PH_PASS;
			end else begin
				phase_q = PH_HOLD;
			end
			si = int'(sel_q);
			if (si > LANES - 1)
				si = LANES - 1;
			g = longint'(cur[si]) * longint'(gain_q);
			g = g >>> 8;
			k = longint'(knee_q);
			if (g > k)
				g = k + ((g - k) >>> 2);
			else if (g < -k)
				g = -k + ((g + k) >>> 2);
			if (g > longint'(SAT_HI))
				g = longint'(SAT_HI);
			if (g < longint'(SAT_LO))
				g = longint'(SAT_LO);
			for (int i = 0; i < LANES; i++)
				r[i*SAMPLE_W +: SAMPLE_W] = cur[i];
			r[LANES*SAMPLE_W +: SAMPLE_W] = g[SAMPLE_W-1:0];
			emits = 1'b1;
		end
	endtask

	task automatic push_frame(input logic [IN_W-1:0] f, input bit typed,
			input logic [OUT_W-1:0] typed_res);
		bit               emits;
		logic [OUT_W-1:0] r;
		while (gaps_on && $urandom_range(0, 99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= f;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		resample_frame(f, emits, r);
		if (emits)
			pending_frames.push_back(typed ? typed_res : r);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_GAIN: gain_q = val[GAIN_W-1:0];
			REG_KNEE: knee_q = val[KNEE_W-1:0];
			REG_SEL:  sel_q = val[SEL_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// block goes idle: no request in flight, every result out, pipe flushed
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic row_item(input logic [IN_W-1:0] f, input bit typed,
			input logic [OUT_W-1:0] r);
		stim_row_t row;
		row = '0;
		row.frame = f;
		row.typed = typed;
		row.res = r;
		directed_rows.push_back(row);
	endtask

	task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val[CFG_DATA_W-1:0];
		directed_rows.push_back(row);
	endtask

	always @(posedge clk)
		m_tready <= gaps_on ? ($urandom_range(0, 99) >= 36) : 1'b1;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				for (int f = 0; f <= LANES; f++) begin
					if (m_tdata[f*SAMPLE_W +: SAMPLE_W] !== want[f*SAMPLE_W +: SAMPLE_W]) begin
						$display("%0t: %s expected %0d got %0d", $time,
							(f == LANES) ? "mic_out" : $sformatf("out_lane%0d", f),
							$signed(want[f*SAMPLE_W +: SAMPLE_W]),
							$signed(m_tdata[f*SAMPLE_W +: SAMPLE_W]));
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		bit in_cfg;
		int waited;
		in_cfg = 1'b0;
		waited = 0;

		// reset values: gain 6x, knee 28000, lane 1
		row_item(pack4(32767, 32767, -32768, 0), 1'b1, pack5(32767, 32767, -32768, 0, 32767));
		row_item(pack4(-32768, -32768, 32767, -1), 1'b0, '0);
		row_item(pack4(32767, 32767, -32768, 1), 1'b1, pack5(-1, -1, -1, 0, -6));
		row_item(pack4(0, -32768, 1, -1), 1'b1, pack5(0, -32768, 1, -1, -32768));
		row_item(pack4(100, 200, 300, 400), 1'b0, '0);
		row_item(pack4(101, 203, -300, 400), 1'b0, '0);
		// max gain, zero knee: every nonzero value gets quartered
		row_cfg(REG_GAIN, 16383);
		row_cfg(REG_KNEE, 0);
		row_cfg(REG_SEL, 3);
		row_item(pack4(1, -1, 2, -2), 1'b1, pack5(1, -1, 2, -2, -32));
		row_item(pack4(-7, 9, -20000, 0), 1'b0, '0);
		row_item(pack4(8, -9, 20001, 0), 1'b0, '0);
		row_item(pack4(32767, -32768, 12345, 32767), 1'b1,
			pack5(32767, -32768, 12345, 32767, 32767));
		row_cfg(REG_GAIN, 0);
		row_cfg(REG_KNEE, 32767);
		row_cfg(REG_SEL, 0);
		row_item(pack4(3, 4, 5, 6), 1'b0, '0);
		row_item(pack4(-3, -4, -5, -6), 1'b0, '0);
		row_item(pack4(-32768, 5, 5, 5), 1'b1, pack5(-32768, 5, 5, 5, 0));
		row_cfg(REG_UNMAPPED, 32767);
		row_cfg(REG_GAIN, 256);
		row_cfg(REG_SEL, 2);
		row_item(pack4(-32768, 32767, -32768, 32767), 1'b0, '0);
		row_item(pack4(32767, -32768, 32767, -32768), 1'b0, '0);
		row_item(pack4(1000, -1000, -32768, 77), 1'b0, '0);
		row_item(pack4(-5, 5, 32767, -77), 1'b0, '0);
		row_item(pack4(-6, 6, -32767, 78), 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].is_cfg) begin
				if (!in_cfg)
					settle();
				write_reg(directed_rows[r].idx, directed_rows[r].val);
			end else begin
				push_frame(directed_rows[r].frame, directed_rows[r].typed,
					directed_rows[r].res);
			end
			in_cfg = directed_rows[r].is_cfg;
		end

		for (int round = 0; round < RAND_ROUNDS; round++) begin
			settle();
			// one round runs with both sides streaming flat out
			gaps_on = (round != 3);
			case ($urandom_range(0, 5))
				0: write_reg(REG_GAIN, 0);
				1: write_reg(REG_GAIN, 16383);
				2: write_reg(REG_GAIN, 256);
				3: write_reg(REG_GAIN, CFG_DATA_W'(GAIN_RESET));
				default: write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(0, 32767)));
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(REG_KNEE, 0);
				1: write_reg(REG_KNEE, 32767);
				2: write_reg(REG_KNEE, KNEE_RESET);
				default: write_reg(REG_KNEE, CFG_DATA_W'($urandom_range(0, 32767)));
			endcase
			write_reg(REG_SEL, CFG_DATA_W'($urandom_range(0, 3)));
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 32767)));
			for (int n = 0; n < ROUND_ITEMS; n++)
				push_frame(pack4(rand_sample(), rand_sample(), rand_sample(), rand_sample()),
					1'b0, '0);
		end

		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_frames.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/rsg_pkg.sv
rtl/rsg_lane.sv
rtl/rsg_merge.sv
rtl/four_lane_3to2_resampler_soft_gain_top.sv
rtl/rsg_checker.sv
test/four_lane_3to2_resampler_soft_gain_top_tb.sv
